[sv/vdi_pkg.sv]
package vdi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 10;
    localparam int WORD_W      = 32;
    localparam int KEY_W       = 8 * WORD_W;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic              new_mesh;
        logic [WORD_W-1:0] pos_x;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] norm_x;
        logic [WORD_W-1:0] norm_y;
        logic [WORD_W-1:0] norm_z;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] tex_v;
    } vertex_item_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 is_new;
        logic                 overflow;
    } result_item_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] entries;
    } back_status_t;

    function automatic key_t key_of(input vertex_item_t v);
        key_t k;
        k = {v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z, v.tex_u, v.tex_v};
        return k;
    endfunction

endpackage

[sv/vdi_in_queue.sv]
module vdi_in_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  vdi_pkg::vertex_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_pop,
    output vdi_pkg::vertex_item_t rd_item
);

    vdi_pkg::vertex_item_t slot_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = rd_pop && rd_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[sv/vdi_search.sv]
module vdi_search (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  vdi_pkg::vertex_item_t q_item,
    output logic                  empty,
    input  logic                  pop,
    output vdi_pkg::result_item_t result,
    output vdi_pkg::back_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } state_t;

    state_t                       state_reg, state_next;
    logic [vdi_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [vdi_pkg::CNT_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [vdi_pkg::CNT_W-1:0]    cmp_slot_reg;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic                         hit_reg, hit_next;
    logic [vdi_pkg::CNT_W-1:0]    hit_slot_reg, hit_slot_next;
    logic                         res_valid_reg, res_valid_next;
    vdi_pkg::result_item_t        res_reg, res_next;
    vdi_pkg::key_t                key_reg;
    vdi_pkg::key_t                rd_data_reg;
    vdi_pkg::key_t                mem [vdi_pkg::TABLE_DEPTH];
    logic                         mem_we;
    logic [vdi_pkg::CNT_W-1:0]    count_eff;
    logic                         res_free;
    logic                         is_last;

    assign count_eff = q_item.new_mesh ? '0 : count_reg;
    assign res_free  = !res_valid_reg || pop;
    assign is_last   = (cmp_slot_reg == vdi_pkg::CNT_W'(count_reg - vdi_pkg::CNT_W'(1)));
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign empty     = !res_valid_reg;
    assign result    = res_reg;
    assign status    = '{busy: (state_reg != S_IDLE), entries: count_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        mem_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    count_next   = count_eff;
                    rd_addr_next = '0;
                    hit_next     = 1'b0;
                    if (count_eff == '0)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                cmp_valid_next = (rd_addr_reg < count_reg);
                if (rd_addr_reg < count_reg)
                begin
                    rd_addr_next = rd_addr_reg + vdi_pkg::CNT_W'(1);
                end
                if (cmp_valid_reg && (rd_data_reg == key_reg))
                begin
                    hit_next       = 1'b1;
                    hit_slot_next  = cmp_slot_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_COMMIT;
                end
                else if (cmp_valid_reg && is_last)
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (hit_reg)
                    begin
                        res_next = '{vertex_index: vdi_pkg::OUT_IDX_W'(hit_slot_reg),
                                     is_new: 1'b0, overflow: 1'b0};
                    end
                    else if (count_reg < vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + vdi_pkg::CNT_W'(1);
                        res_next   = '{vertex_index: vdi_pkg::OUT_IDX_W'(count_reg),
                                       is_new: 1'b1, overflow: 1'b0};
                    end
                    else
                    begin
                        res_next = '{vertex_index: '0, is_new: 1'b0, overflow: 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            cmp_slot_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            hit_slot_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            key_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_slot_reg  <= rd_addr_reg;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            hit_slot_reg  <= hit_slot_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            if (q_pop)
            begin
                key_reg <= vdi_pkg::key_of(q_item);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr_reg[vdi_pkg::IDX_W-1:0]];
        if (mem_we)
        begin
            mem[count_reg[vdi_pkg::IDX_W-1:0]] <= key_reg;
        end
    end

endmodule

[sv/vertex_dedup_indexer_top.sv]
// Channel   Handshake        Payload                 Transfer when
// vertex    push / full      vdi_pkg::vertex_item_t  push high and full low
// result    pop / empty      vdi_pkg::result_item_t  pop high and empty low
//
// A vertex waits in a two-entry input queue, then the search unit reads one stored
// entry per cycle from its table memory and compares it in the following cycle.
// The search stops at the first stored entry that matches or after the last one;
// an item that starts a new mesh empties the table and skips the search.
// Reset clears the entry count and all queues; the table memory is not cleared.
// A result held on the output stalls only the commit step; up to two vertices
// may still be accepted meanwhile.
module vertex_dedup_indexer_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  vdi_pkg::vertex_item_t vertex,
    output logic                  empty,
    input  logic                  pop,
    output vdi_pkg::result_item_t result
);

    logic                  q_valid;
    logic                  q_pop;
    vdi_pkg::vertex_item_t q_item;
    vdi_pkg::back_status_t status;

    vdi_in_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .wr_item  (vertex),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    vdi_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .status  (status)
    );

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !status.busy)
        else $error("search unit took an item from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.entries <= vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.is_new && result.overflow))
        else $error("result both new and overflowed");

    a_new_grows_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(empty) && result.is_new) |-> status.entries != '0)
        else $error("new entry reported with an empty table");

endmodule
